// File: sv/aeskx_pkg.sv
// Shared types, constants and helper functions for the AES key expansion block.
package aeskx_pkg;

  localparam int MAX_KEY_WORDS      = 8;
  localparam int MAX_SCHEDULE_WORDS = 60;
  localparam int KEY_IDX_W          = $clog2(MAX_KEY_WORDS);
  localparam int WORD_IDX_W         = $clog2(MAX_SCHEDULE_WORDS);
  localparam int CFG_W              = 4;
  localparam int CFG_IDX_W          = 2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_KEY_WORDS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_ROUNDS    = 2'd1;

  localparam logic [CFG_W-1:0] KEY_WORDS_MIN = 4'd4;
  localparam logic [CFG_W-1:0] KEY_WORDS_MAX = 4'd8;
  localparam logic [CFG_W-1:0] ROUNDS_MIN    = 4'd10;
  localparam logic [CFG_W-1:0] ROUNDS_MAX    = 4'd14;
  localparam logic [CFG_W-1:0] ROUNDS_CAP    = 4'd13;
  localparam logic [CFG_W-1:0] SUB_ONLY_NK   = 4'd6;

  localparam logic [7:0] RCON_INIT = 8'h01;
  localparam logic [7:0] GF_POLY   = 8'h1b;

  // Control for one step of the word unit
  typedef struct packed {
    logic rot;  // rotate, substitute and add round constant
    logic sub;  // substitute only
  } step_ctl_t;

  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  // Substitute each byte of a word
  function automatic logic [31:0] sub_word(input logic [31:0] w);
    return {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
  endfunction

  // Multiply by x in GF(2^8)
  function automatic logic [7:0] xtime(input logic [7:0] b);
    return {b[6:0], 1'b0} ^ (b[7] ? GF_POLY : 8'h00);
  endfunction

  // Effective key length in words
  function automatic logic [CFG_W-1:0] clamp_nk(input logic [CFG_W-1:0] kw);
    logic [CFG_W-1:0] nk;
    nk = kw;
    if (nk < KEY_WORDS_MIN) nk = KEY_WORDS_MIN;
    if (nk > KEY_WORDS_MAX) nk = KEY_WORDS_MAX;
    return nk;
  endfunction

  // Schedule length 4*(Nr+1) with Nr clamped to fit the schedule store
  function automatic logic [WORD_IDX_W-1:0] schedule_total(input logic [CFG_W-1:0] nk,
                                                           input logic [CFG_W-1:0] nr);
    logic [CFG_W-1:0] nr_c;
    logic [CFG_W-1:0] lim;
    nr_c = nr;
    if (nr_c < ROUNDS_MIN) nr_c = ROUNDS_MIN;
    if (nr_c > ROUNDS_MAX) nr_c = ROUNDS_MAX;
    lim = (nk == KEY_WORDS_MAX) ? ROUNDS_MAX : ROUNDS_CAP;
    if (nr_c > lim) nr_c = lim;
    return {nr_c + 4'd1, 2'b00};
  endfunction

endpackage

// File: sv/aeskx_if.sv
// Valid/ready channel interfaces for key words in and schedule words out.
interface aeskx_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] key_word;

  modport source (output valid, output key_word, input ready);
  modport sink   (input valid, input key_word, output ready);
endinterface

interface aeskx_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] round_key_word;
  logic [5:0]  word_index;
  logic        last_word;

  modport source (output valid, output round_key_word, output word_index, output last_word,
                  input ready);
  modport sink   (input valid, input round_key_word, input word_index, input last_word,
                  output ready);
endinterface

// File: sv/aeskx_word_unit.sv
// Shared word unit: computes one expanded schedule word per use.
module aeskx_word_unit
  import aeskx_pkg::*;
(
  input  logic [31:0] prev_word,
  input  logic [31:0] back_word,
  input  logic [7:0]  rcon,
  input  step_ctl_t   ctl,
  output logic [31:0] new_word
);

  logic [31:0] sub_w;
  logic [31:0] t_w;

  // Substitute first; rotation commutes with byte substitution
  assign sub_w = sub_word(prev_word);

  always_comb begin
    priority if (ctl.rot) begin
      t_w = {sub_w[7:0], sub_w[31:8]} ^ {24'h0, rcon};
    end else if (ctl.sub) begin
      t_w = sub_w;
    end else begin
      t_w = prev_word;
    end
  end

  assign new_word = t_w ^ back_word;

endmodule

// File: sv/aes_key_expansion.sv
// Top level: AES key schedule generator with a serial word unit.
//
// Usage: set key_words (index 0) and rounds (index 1) on the cfg port while
// idle, then send the cipher key one 32-bit word per beat on in_key, first
// key byte in bits 7..0. Every key word comes back on out_rk with its schedule
// index. After the last key word the block generates the remaining schedule
// words, one per cycle while the receiver does not stall, through a single
// shared word unit (S-box lookup, round constant and XOR); last_word marks
// the final one. A key word appears on out_rk the cycle after it is taken.
// The last key word is followed by generation of the remaining 4*(Nr+1)-Nk
// schedule words (36 to 52), during which in_key is not ready.
// The result sits in an output register; a stalled receiver freezes the
// block, and a new key word is taken in the same cycle as the held result
// leaves. A key word that arrives after a finished schedule starts a new key.
// Reset (synchronous, rst_n low) empties the output, restarts the key count,
// and sets key_words to 4 and rounds to 10. No clearing pass is needed.
module aes_key_expansion
  import aeskx_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  aeskx_in_if.sink             in_key,
  aeskx_out_if.source          out_rk,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  typedef enum logic {S_IDLE, S_GEN} state_t;

  state_t                 state_r;
  logic [CFG_W-1:0]       key_words_r;
  logic [CFG_W-1:0]       rounds_r;
  logic [WORD_IDX_W-1:0]  wc_r;
  logic [7:0]             rcon_r;
  logic [CFG_W-1:0]       nk_r;
  logic [WORD_IDX_W-1:0]  total_r;
  logic [WORD_IDX_W-1:0]  idx_r;
  logic [KEY_IDX_W-1:0]   rmod_r;
  logic [31:0]            prev_r;
  logic [31:0]            window_r [MAX_KEY_WORDS];
  logic                   out_valid_r;
  logic [31:0]            out_word_r;
  logic [WORD_IDX_W-1:0]  out_idx_r;
  logic                   out_last_r;

  logic                   out_free;
  logic                   in_fire;
  logic                   gen_fire;
  logic [CFG_W-1:0]       nk_eff;
  logic                   new_key;
  logic [WORD_IDX_W-1:0]  wc_start;
  logic [WORD_IDX_W-1:0]  wc_nxt;
  logic                   gen_last;
  step_ctl_t              ctl;
  logic [31:0]            gen_word;

  // Handshake
  assign out_free     = !out_valid_r || out_rk.ready;
  assign in_key.ready = (state_r == S_IDLE) && out_free;
  assign in_fire      = in_key.valid && in_key.ready;
  assign gen_fire     = (state_r == S_GEN) && out_free;

  assign out_rk.valid          = out_valid_r;
  assign out_rk.round_key_word = out_word_r;
  assign out_rk.word_index     = out_idx_r;
  assign out_rk.last_word      = out_last_r;

  // Key word position for the incoming beat
  assign nk_eff   = clamp_nk(key_words_r);
  assign new_key  = wc_r >= {{(WORD_IDX_W-CFG_W){1'b0}}, nk_eff};
  assign wc_start = new_key ? '0 : wc_r;
  assign wc_nxt   = wc_start + 1'b1;

  // Step selection for the word unit
  assign ctl.rot  = (rmod_r == '0);
  assign ctl.sub  = (nk_r > SUB_ONLY_NK) && ({1'b0, rmod_r} == 4'd4);
  assign gen_last = (idx_r == total_r - 1'b1);

  aeskx_word_unit u_word (
    .prev_word (prev_r),
    .back_word (window_r[rmod_r]),
    .rcon      (rcon_r),
    .ctl       (ctl),
    .new_word  (gen_word)
  );

  // Hold the last Nk schedule words
  always_ff @(posedge clk) begin
    if (in_fire) begin
      window_r[wc_start[KEY_IDX_W-1:0]] <= in_key.key_word;
    end else if (gen_fire) begin
      window_r[rmod_r] <= gen_word;
    end
  end

  // Sequencer, configuration and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      key_words_r <= KEY_WORDS_MIN;
      rounds_r    <= ROUNDS_MIN;
      wc_r        <= '0;
      rcon_r      <= RCON_INIT;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == CFG_IDX_KEY_WORDS) key_words_r <= cfg_data;
        if (cfg_index == CFG_IDX_ROUNDS)    rounds_r    <= cfg_data;
      end
      // Drop the result once taken unless a new one replaces it
      if (out_rk.ready && !in_fire && !gen_fire) out_valid_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (in_fire) begin
            if (new_key) rcon_r <= RCON_INIT;
            wc_r        <= wc_nxt;
            prev_r      <= in_key.key_word;
            out_valid_r <= 1'b1;
            out_word_r  <= in_key.key_word;
            out_idx_r   <= wc_start;
            out_last_r  <= 1'b0;
            // Last key word: start generating
            if (wc_nxt == {{(WORD_IDX_W-CFG_W){1'b0}}, nk_eff}) begin
              state_r <= S_GEN;
              nk_r    <= nk_eff;
              total_r <= schedule_total(nk_eff, rounds_r);
              idx_r   <= {{(WORD_IDX_W-CFG_W){1'b0}}, nk_eff};
              rmod_r  <= '0;
            end
          end
        end
        S_GEN: begin
          if (gen_fire) begin
            prev_r      <= gen_word;
            out_valid_r <= 1'b1;
            out_word_r  <= gen_word;
            out_idx_r   <= idx_r;
            out_last_r  <= gen_last;
            if (ctl.rot) rcon_r <= xtime(rcon_r);
            rmod_r <= ({1'b0, rmod_r} == nk_r - 4'd1) ? '0 : rmod_r + 1'b1;
            idx_r  <= idx_r + 1'b1;
            if (gen_last) begin
              state_r <= S_IDLE;
              wc_r    <= total_r;
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

// File: sv/aeskx_checker.sv
// Port-level assertions for the key expansion block, bound to the top level.
module aeskx_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] out_word,
  input logic [5:0]  out_index,
  input logic        out_last
);

  // Stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_word) && $stable(out_index)
      && $stable(out_last))
    else $error("stalled result changed");

  // Every key word beat shows up as a result next cycle
  a_key_echo: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> out_valid)
    else $error("key word not forwarded");

  // Final word lands only at a legal schedule length
  a_last_idx: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last |-> out_index == 6'd43 || out_index == 6'd47 ||
      out_index == 6'd51 || out_index == 6'd55 || out_index == 6'd59)
    else $error("last word at bad index");

  // Output is empty after reset
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid after reset");

endmodule

bind aes_key_expansion aeskx_checker u_aeskx_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_key.valid),
  .in_ready  (in_key.ready),
  .out_valid (out_rk.valid),
  .out_ready (out_rk.ready),
  .out_word  (out_rk.round_key_word),
  .out_index (out_rk.word_index),
  .out_last  (out_rk.last_word)
);

// File: tb/tb_aes_key_expansion.sv
// Self-checking testbench for aes_key_expansion: random keys and sizes, checked word by word.
module tb_aes_key_expansion;
  import aeskx_pkg::*;

  localparam int          WINDOW_DEPTH   = 8;
  localparam int          NK_FLOOR       = 4;
  localparam int          NK_CEIL        = 8;
  localparam int          NR_FLOOR       = 10;
  localparam int          NR_CEIL        = 14;
  localparam int          SUB_ONLY_ABOVE = 6;
  localparam int          SUB_ONLY_SLOT  = 4;
  localparam logic [7:0]  RCON_FIRST     = 8'h01;
  localparam logic [7:0]  GF_REDUCE      = 8'h1b;
  localparam logic [7:0]  AFFINE_CONST   = 8'h63;
  localparam logic [CFG_W-1:0] KEY_WORDS_AT_RESET = 4'd4;
  localparam logic [CFG_W-1:0] ROUNDS_AT_RESET    = 4'd10;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE_LO = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE_HI = 2'd3;
  localparam int TOTAL_ITEMS   = 520;
  localparam int TAIL_CYCLES   = 64;
  localparam int STALL_LIMIT   = 4000;

  typedef struct {
    logic [31:0] word;
    logic [5:0]  index;
    logic        last;
  } sched_word_t;

  // Tracks the key schedule state and holds the words still owed by the block
  class key_schedule_tracker;
    logic [7:0]       sbox_table [256];
    logic [31:0]      window [WINDOW_DEPTH];
    int unsigned      words_taken;
    logic [7:0]       rcon;
    logic [CFG_W-1:0] key_words_reg;
    logic [CFG_W-1:0] rounds_reg;
    sched_word_t      owed_words [$];
    int               errors;

    // Build the S-box from the GF(2^8) inverse and the affine map
    function new();
      logic [7:0] inv;
      for (int x = 0; x < 256; x++) begin
        inv = 8'h00;
        for (int y = 1; y < 256; y++)
          if (gf_mul(8'(x), 8'(y)) == 8'h01) inv = 8'(y);
        sbox_table[x] = inv ^ {inv[6:0], inv[7]} ^ {inv[5:0], inv[7:6]} ^
                        {inv[4:0], inv[7:5]} ^ {inv[3:0], inv[7:4]} ^ AFFINE_CONST;
      end
      errors = 0;
      reset_state();
    endfunction

    function logic [7:0] gf_mul(logic [7:0] a, logic [7:0] b);
      logic [7:0] p;
      p = 8'h00;
      for (int k = 0; k < 8; k++) begin
        if (b[k]) p ^= a;
        a = {a[6:0], 1'b0} ^ (a[7] ? GF_REDUCE : 8'h00);
      end
      return p;
    endfunction

    function logic [31:0] sub_bytes(logic [31:0] w);
      return {sbox_table[w[31:24]], sbox_table[w[23:16]],
              sbox_table[w[15:8]], sbox_table[w[7:0]]};
    endfunction

    function void reset_state();
      words_taken   = 0;
      rcon          = RCON_FIRST;
      key_words_reg = KEY_WORDS_AT_RESET;
      rounds_reg    = ROUNDS_AT_RESET;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
      case (idx)
        CFG_IDX_KEY_WORDS: key_words_reg = val;
        CFG_IDX_ROUNDS:    rounds_reg = val;
        default: ;
      endcase
    endfunction

    function int unsigned effective_nk();
      int unsigned nk;
      nk = key_words_reg;
      if (nk < NK_FLOOR) nk = NK_FLOOR;
      if (nk > NK_CEIL) nk = NK_CEIL;
      return nk;
    endfunction

    // Clamp rounds, then cap so the schedule fits in nk+52 words
    function int unsigned schedule_length(int unsigned nk);
      int unsigned nr;
      int unsigned cap;
      nr  = rounds_reg;
      cap = (nk + 52) / 4 - 1;
      if (nr < NR_FLOOR) nr = NR_FLOOR;
      if (nr > NR_CEIL) nr = NR_CEIL;
      if (nr > cap) nr = cap;
      return 4 * (nr + 1);
    endfunction

    function int pending();
      return owed_words.size();
    endfunction

    // Take one key word; on the last one, expand the rest of the schedule
    function void note_key_word(logic [31:0] w);
      int unsigned nk;
      int unsigned total;
      int unsigned slot;
      logic [31:0] t;
      sched_word_t e;
      nk    = effective_nk();
      total = schedule_length(nk);
      if (words_taken >= nk) begin
        words_taken = 0;
        rcon = RCON_FIRST;
      end
      window[words_taken % nk] = w;
      e.word  = w;
      e.index = 6'(words_taken);
      e.last  = 1'b0;
      owed_words.push_back(e);
      words_taken++;
      if (words_taken == nk) begin
        for (int unsigned i = nk; i < total; i++) begin
          t    = window[(i - 1) % nk];
          slot = i % nk;
          if (slot == 0) begin
            t    = sub_bytes({t[7:0], t[31:8]}) ^ {24'h0, rcon};
            rcon = {rcon[6:0], 1'b0} ^ (rcon[7] ? GF_REDUCE : 8'h00);
          end else if (nk > SUB_ONLY_ABOVE && slot == SUB_ONLY_SLOT) begin
            t = sub_bytes(t);
          end
          t ^= window[slot];
          window[slot] = t;
          e.word  = t;
          e.index = 6'(i);
          e.last  = (i + 1 == total);
          owed_words.push_back(e);
        end
        words_taken = total;
      end
    endfunction

    // Compare one schedule word with the oldest owed one
    function void check_result(logic [31:0] w, logic [5:0] idx, logic last);
      sched_word_t e;
      if (owed_words.size() == 0) begin
        errors++;
        $error("unexpected schedule word %h at index %0d", w, idx);
        return;
      end
      e = owed_words.pop_front();
      if (w !== e.word) begin
        errors++;
        $error("round_key_word expected %h, got %h", e.word, w);
      end
      if (idx !== e.index) begin
        errors++;
        $error("word_index expected %0d, got %0d", e.index, idx);
      end
      if (last !== e.last) begin
        errors++;
        $error("last_word expected %0b, got %0b", e.last, last);
      end
    endfunction
  endclass

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_data;
  int                   tx_idle_pct;
  int                   rx_idle_pct;
  int                   items_sent;
  int                   quiet_cycles;
  key_schedule_tracker  tracker = new();

  aeskx_in_if  key_in ();
  aeskx_out_if rk_out ();

  aes_key_expansion u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_key    (key_in),
    .out_rk    (rk_out),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // Stall the receiver at random
  always @(posedge clk) begin
    rk_out.ready <= ($urandom_range(99) >= rx_idle_pct);
  end

  // Check every schedule word beat
  always @(posedge clk) begin
    if (rst_n && rk_out.valid && rk_out.ready)
      tracker.check_result(rk_out.round_key_word, rk_out.word_index, rk_out.last_word);
  end

  // Abort when neither channel moves for too long
  always @(posedge clk) begin
    if ((key_in.valid && key_in.ready) || (rk_out.valid && rk_out.ready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("aes_key_expansion test failed");
      $finish;
    end
  end

  function automatic logic [31:0] pick_key_word();
    case ($urandom_range(15))
      0:       return 32'h0000_0000;
      1:       return 32'hffff_ffff;
      default: return $urandom;
    endcase
  endfunction

  // Offer one key word, idling at random first, and hold until taken
  task automatic send_key_word(input logic [31:0] w);
    while ($urandom_range(99) < tx_idle_pct) begin
      key_in.valid <= 1'b0;
      @(posedge clk);
    end
    key_in.valid    <= 1'b1;
    key_in.key_word <= w;
    do @(posedge clk); while (!key_in.ready);
    tracker.note_key_word(w);
    items_sent++;
  endtask

  // Drop valid and wait until every owed word has come out
  task automatic wait_schedule_done();
    key_in.valid <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk);
    @(posedge clk);
  endtask

  // Write key size and rounds, sometimes followed by a write to an unused index
  task automatic program_regs(input logic [CFG_W-1:0] kw, input logic [CFG_W-1:0] nr);
    logic [CFG_IDX_W-1:0] spare_idx;
    logic [CFG_W-1:0]     spare_data;
    spare_idx  = $urandom_range(1) ? CFG_IDX_SPARE_HI : CFG_IDX_SPARE_LO;
    spare_data = CFG_W'($urandom);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_IDX_KEY_WORDS;
    cfg_data  <= kw;
    @(posedge clk);
    tracker.write_reg(CFG_IDX_KEY_WORDS, kw);
    cfg_index <= CFG_IDX_ROUNDS;
    cfg_data  <= nr;
    @(posedge clk);
    tracker.write_reg(CFG_IDX_ROUNDS, nr);
    if ($urandom_range(3) == 0) begin
      cfg_index <= spare_idx;
      cfg_data  <= spare_data;
      @(posedge clk);
      tracker.write_reg(spare_idx, spare_data);
    end
    cfg_we <= 1'b0;
  endtask

  initial begin
    logic [CFG_W-1:0] kw;
    logic [CFG_W-1:0] nr;
    int unsigned      nk;
    int unsigned      n;
    bit               partial;
    rst_n           <= 1'b0;
    key_in.valid    <= 1'b0;
    key_in.key_word <= 32'h0;
    cfg_we          <= 1'b0;
    cfg_index       <= CFG_IDX_KEY_WORDS;
    cfg_data        <= '0;
    items_sent      = 0;
    quiet_cycles    = 0;
    partial         = 1'b0;
    tx_idle_pct     = 29;
    rx_idle_pct     = 64;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset size (128-bit key) with word extremes
    send_key_word(32'h0000_0000);
    send_key_word(32'hffff_ffff);
    send_key_word(32'h1615_7e2b);
    send_key_word(32'h3c4f_cf09);
    wait_schedule_done();

    // 192-bit key, 12 rounds
    program_regs(4'd6, 4'd12);
    repeat (6) send_key_word(pick_key_word());
    wait_schedule_done();

    // 256-bit key, 14 rounds: substitute-only words appear
    program_regs(4'd8, 4'd14);
    send_key_word(32'hffff_ffff);
    send_key_word(32'h0000_0000);
    repeat (6) send_key_word(pick_key_word());
    wait_schedule_done();

    // Out-of-range sizes clamp; start a long key, then shrink it mid-load
    program_regs(4'd15, 4'd0);
    repeat (5) send_key_word(pick_key_word());
    wait_schedule_done();
    // Shrinking below the words taken restarts the key; rounds cap at 13 so
    // the round constant runs past 0x36
    program_regs(4'd0, 4'd15);
    repeat (4) send_key_word(pick_key_word());

    // Random keys: mostly whole keys, some cut short and resized mid-load
    while (items_sent < TOTAL_ITEMS) begin
      if (items_sent >= 2 * TOTAL_ITEMS / 3) begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end else if (items_sent >= TOTAL_ITEMS / 3) begin
        tx_idle_pct = 64;
        rx_idle_pct = 29;
      end
      if (partial || $urandom_range(2) == 0) begin
        wait_schedule_done();
        kw = ($urandom_range(9) == 0) ? CFG_W'($urandom_range(15))
                                      : CFG_W'(4 + 2 * $urandom_range(2));
        nr = ($urandom_range(4) == 0) ? CFG_W'($urandom_range(15))
                                      : CFG_W'($urandom_range(14, 10));
        program_regs(kw, nr);
      end
      nk      = tracker.effective_nk();
      partial = ($urandom_range(7) == 0);
      n       = partial ? $urandom_range(nk - 1, 1) : nk;
      repeat (n) send_key_word(pick_key_word());
    end

    // Let the last schedule drain, then watch for stray words
    wait_schedule_done();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (tracker.errors == 0 && tracker.pending() == 0)
      $display("aes_key_expansion test passed");
    else
      $display("aes_key_expansion test failed");
    $finish;
  end

endmodule
